### rtl/rhs_pkg.sv
// Shared types and constants for the RGBA histogram statistics block.
package rhs_pkg;

   // Item action codes
   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_PIXEL = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   // Channel codes, also the bank numbers
   localparam int NUM_CHANNELS = 5;
   localparam logic [2:0] CH_VALUE = 3'd0;
   localparam logic [2:0] CH_RED   = 3'd1;
   localparam logic [2:0] CH_GREEN = 3'd2;
   localparam logic [2:0] CH_BLUE  = 3'd3;
   localparam logic [2:0] CH_ALPHA = 3'd4;

   // Field widths
   localparam int SAMPLE_W = 8;
   localparam int TOTAL_W  = 40;
   localparam int MEAN_W   = 16;
   localparam int SD_BITS  = 15;
   localparam int PEAK_W   = 32;

   // Arithmetic widths
   localparam int SUM_W      = 64;
   localparam int PROD_W     = 2 * SUM_W;
   localparam int STEP_CNT_W = $clog2(SUM_W + 1);
   localparam int FRAC_BITS  = 8;
   localparam int VAR_SHIFT  = 2 * FRAC_BITS;

   localparam logic [SUM_W-1:0]  TOTAL_MAX = SUM_W'({TOTAL_W{1'b1}});
   localparam logic [SUM_W-1:0]  MEAN_MAX  = SUM_W'({MEAN_W{1'b1}});
   localparam logic [SUM_W-1:0]  PEAK_MAX  = SUM_W'({PEAK_W{1'b1}});

   // Bank commands
   typedef enum logic [1:0] {
      BANK_NOP,
      BANK_INC,
      BANK_READ,
      BANK_CLEAR
   } bank_op_type;

endpackage

### rtl/rhs_bank.sv
// One histogram bank: counter memory with read, clear and a saturating read-modify-write increment with forwarding.
module rhs_bank import rhs_pkg::*; #(
   parameter int BINS       = 256,
   parameter int COUNT_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bank_op_type                cmd_op,
   input  logic [$clog2(BINS)-1:0]    cmd_addr,
   output logic [COUNT_BITS-1:0]      rd_count
);

   localparam int IDX_W = $clog2(BINS);

   logic [COUNT_BITS-1:0] mem [0:BINS-1];

   logic [COUNT_BITS-1:0] rdata_ff;
   logic [IDX_W-1:0]      addr_ff;
   logic                  inc_ff;
   logic                  fwd_valid_ff;
   logic [IDX_W-1:0]      fwd_addr_ff;
   logic [COUNT_BITS-1:0] fwd_data_ff;

   logic                  rd_req;
   logic                  clr;
   logic [COUNT_BITS-1:0] cur;
   logic [COUNT_BITS-1:0] bumped;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [COUNT_BITS-1:0] wr_data;

   // Current count: the write of the read edge is not yet in the read data
   always_comb begin
      rd_req  = (cmd_op == BANK_INC) || (cmd_op == BANK_READ);
      clr     = (cmd_op == BANK_CLEAR);
      cur     = (fwd_valid_ff && (fwd_addr_ff == addr_ff)) ? fwd_data_ff : rdata_ff;
      bumped  = (&cur) ? cur : cur + 1'b1;
      wr_en   = clr || inc_ff;
      wr_addr = clr ? cmd_addr : addr_ff;
      wr_data = clr ? '0 : bumped;
   end

   assign rd_count = cur;

   // Memory port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_req) begin
         rdata_ff <= mem[cmd_addr];
         addr_ff  <= cmd_addr;
      end
   end

   // Increment and forwarding control
   always_ff @(posedge clock) begin
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
      if (reset) begin
         inc_ff       <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         inc_ff       <= (cmd_op == BANK_INC);
         fwd_valid_ff <= wr_en;
      end
   end

endmodule

### rtl/rhs_mul.sv
// Shift-add multiplier: full 64x64 product, one multiplier bit per cycle.
module rhs_mul import rhs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  op_a,
   input  logic [SUM_W-1:0]  op_b,
   output logic              done,
   output logic [PROD_W-1:0] product
);

   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic [PROD_W-1:0]     mcand_ff, mcand_in;
   logic [SUM_W-1:0]      mplier_ff, mplier_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;

   // One partial product per cycle
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      if (start) begin
         acc_in    = '0;
         mcand_in  = PROD_W'(op_a);
         mplier_in = op_b;
         cnt_in    = STEP_CNT_W'(SUM_W);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign done    = busy_ff && (cnt_ff == '0);
   assign product = acc_ff;

endmodule

### rtl/rhs_div.sv
// Restoring divider: 64-bit quotient, one quotient bit per cycle.
module rhs_div import rhs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [SUM_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   logic [SUM_W-1:0]      rem_ff, rem_in;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [SUM_W-1:0]      dsr_ff, dsr_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [SUM_W:0]        shifted;
   logic [SUM_W+1:0]      diff;
   logic                  ge;

   // Trial subtract of the shifted remainder
   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      ge      = !diff[SUM_W+1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = STEP_CNT_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign done     = busy_ff && (cnt_ff == '0);
   assign quotient = quo_ff;

endmodule

### rtl/rgba_histogram_statistics.sv
// Pixel transactions: one per cycle while req_stall is low, no result; clear: zeroes every
// bin, then ready. Query: a first pass over the range (count, moments, peak), a median
// pass up to the median bin, then when the count is nonzero the mean divider and 17
// passes of the serial multiplier.
// Reset: synchronous; after reset the block clears all BINS entries and accepts no
// transaction meanwhile.
module rgba_histogram_statistics import rhs_pkg::*; #(
   parameter int BINS       = 256,
   parameter int COUNT_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [SAMPLE_W-1:0] req_blue_sample,
   input  logic [SAMPLE_W-1:0] req_green_sample,
   input  logic [SAMPLE_W-1:0] req_red_sample,
   input  logic [SAMPLE_W-1:0] req_alpha_sample,
   input  logic [2:0]          req_query_channel,
   input  logic [SAMPLE_W-1:0] req_range_start,
   input  logic [SAMPLE_W-1:0] req_range_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [TOTAL_W-1:0]  rsp_bin_total,
   output logic [MEAN_W-1:0]   rsp_mean_q8,
   output logic [SAMPLE_W-1:0] rsp_median_bin,
   output logic [SD_BITS-1:0]  rsp_stddev_q8,
   output logic [PEAK_W-1:0]   rsp_peak_count,
   output logic                rsp_range_error
);

   localparam int IDX_W = $clog2(BINS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BINS - 1);

   typedef enum logic [4:0] {
      S_SWEEP,
      S_RUN,
      S_SCAN_RD,
      S_SCAN_ACC,
      S_SCAN_S1,
      S_SCAN_S2,
      S_MED_RD,
      S_MED_CHK,
      S_DIV_GO,
      S_DIV_WAIT,
      S_MULA_GO,
      S_MULA_WAIT,
      S_MULB_GO,
      S_MULB_WAIT,
      S_SD_GO,
      S_SD_WAIT,
      S_DONE
   } state_type;

   // Clamp a sample to the last bin
   function automatic logic [IDX_W-1:0] bin_of(input logic [SAMPLE_W-1:0] s);
      logic [IDX_W-1:0] r;
      if (32'(s) > 32'(BINS - 1)) begin
         r = LAST_IDX;
      end else begin
         r = IDX_W'(s);
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   logic [IDX_W-1:0]      sweep_ff, sweep_in;
   logic [2:0]            ch_ff, ch_in;
   logic [SAMPLE_W-1:0]   bin_ff, bin_in;
   logic [SAMPLE_W-1:0]   start_ff, start_in;
   logic [SAMPLE_W-1:0]   end_ff, end_in;
   logic                  err_ff, err_in;
   logic [SUM_W-1:0]      n_ff, n_in;
   logic [SUM_W-1:0]      s1_ff, s1_in;
   logic [SUM_W-1:0]      s2_ff, s2_in;
   logic [SUM_W-1:0]      p_ff, p_in;
   logic [SUM_W-1:0]      q_ff, q_in;
   logic [SUM_W-1:0]      cum_ff, cum_in;
   logic [COUNT_BITS-1:0] peak_ff, peak_in;
   logic [SAMPLE_W-1:0]   med_ff, med_in;
   logic [MEAN_W-1:0]     mean_ff, mean_in;
   logic [SD_BITS-1:0]    sd_ff, sd_in;
   logic [3:0]            sd_bit_ff, sd_bit_in;
   logic [PROD_W-1:0]     aprod_ff, aprod_in;
   logic [PROD_W-1:0]     t_ff, t_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [MEAN_W-1:0]     omean_ff, omean_in;
   logic [SAMPLE_W-1:0]   omed_ff, omed_in;
   logic [SD_BITS-1:0]    osd_ff, osd_in;
   logic [PEAK_W-1:0]     opeak_ff, opeak_in;
   logic                  oerr_ff, oerr_in;

   bank_op_type           bank_op    [NUM_CHANNELS];
   logic [IDX_W-1:0]      bank_addr  [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] bank_count [NUM_CHANNELS];
   logic [IDX_W-1:0]      pix_idx    [NUM_CHANNELS];

   logic                  accept;
   logic [SAMPLE_W-1:0]   mx_gb;
   logic [SAMPLE_W-1:0]   mx_rgb;
   logic [COUNT_BITS-1:0] c;
   logic [COUNT_BITS+SAMPLE_W-1:0] p_w;
   logic [SUM_W+SAMPLE_W-1:0]      q_w;
   logic [SUM_W-1:0]      cum_w;
   logic [SD_BITS-1:0]    cand;
   logic [SUM_W+SD_BITS-1:0] qsd_w;
   logic [PROD_W-1:0]     var_w;
   logic [SUM_W-1:0]      peak_x;

   logic                  mul_start;
   logic [SUM_W-1:0]      mul_a;
   logic [SUM_W-1:0]      mul_b;
   logic                  mul_done;
   logic [PROD_W-1:0]     mul_prod;
   logic                  div_start;
   logic                  div_done;
   logic [SUM_W-1:0]      div_quo;

   // Histogram banks
   for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_bank
      rhs_bank #(
         .BINS       (BINS),
         .COUNT_BITS (COUNT_BITS)
      ) u_bank (
         .clock    (clock),
         .reset    (reset),
         .cmd_op   (bank_op[k]),
         .cmd_addr (bank_addr[k]),
         .rd_count (bank_count[k])
      );
   end

   rhs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   rhs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (s1_ff << FRAC_BITS),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_stall = (state_ff != S_RUN);
   assign accept    = req_valid && (state_ff == S_RUN);

   // Datapath terms
   always_comb begin
      mx_gb  = (req_blue_sample > req_green_sample) ? req_blue_sample : req_green_sample;
      mx_rgb = (req_red_sample > mx_gb) ? req_red_sample : mx_gb;
      pix_idx[CH_VALUE] = bin_of(mx_rgb);
      pix_idx[CH_RED]   = bin_of(req_red_sample);
      pix_idx[CH_GREEN] = bin_of(req_green_sample);
      pix_idx[CH_BLUE]  = bin_of(req_blue_sample);
      pix_idx[CH_ALPHA] = bin_of(req_alpha_sample);
      c      = bank_count[ch_ff];
      p_w    = {{COUNT_BITS{1'b0}}, bin_ff} * {{SAMPLE_W{1'b0}}, c};
      q_w    = {{SUM_W{1'b0}}, bin_ff} * {{SAMPLE_W{1'b0}}, p_ff};
      cum_w  = cum_ff + SUM_W'(c);
      cand   = sd_ff | (SD_BITS'(1) << sd_bit_ff);
      qsd_w  = {{SUM_W{1'b0}}, cand} * {{SD_BITS{1'b0}}, n_ff};
      var_w  = (aprod_ff - mul_prod) << VAR_SHIFT;
      peak_x = SUM_W'(peak_ff);
   end

   // Multiplier operand select
   always_comb begin
      case (state_ff)
         S_MULA_GO: begin
            mul_a = n_ff;
            mul_b = s2_ff;
         end
         S_MULB_GO: begin
            mul_a = s1_ff;
            mul_b = s1_ff;
         end
         default: begin
            mul_a = qsd_w[SUM_W-1:0];
            mul_b = qsd_w[SUM_W-1:0];
         end
      endcase
   end

   // Control and statistics sequencer
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      ch_in        = ch_ff;
      bin_in       = bin_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      err_in       = err_ff;
      n_in         = n_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      cum_in       = cum_ff;
      peak_in      = peak_ff;
      med_in       = med_ff;
      mean_in      = mean_ff;
      sd_in        = sd_ff;
      sd_bit_in    = sd_bit_ff;
      aprod_in     = aprod_ff;
      t_in         = t_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      total_in     = total_ff;
      omean_in     = omean_ff;
      omed_in      = omed_ff;
      osd_in       = osd_ff;
      opeak_in     = opeak_ff;
      oerr_in      = oerr_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         bank_op[k]   = BANK_NOP;
         bank_addr[k] = '0;
      end

      case (state_ff)
         S_SWEEP: begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
               bank_op[k]   = BANK_CLEAR;
               bank_addr[k] = sweep_ff;
            end
            if (sweep_ff == LAST_IDX) begin
               sweep_in = '0;
               state_in = S_RUN;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         S_RUN: begin
            if (accept) begin
               case (req_action)
                  ACT_CLEAR: begin
                     sweep_in = '0;
                     state_in = S_SWEEP;
                  end
                  ACT_PIXEL: begin
                     for (int k = 0; k < NUM_CHANNELS; k++) begin
                        bank_op[k]   = BANK_INC;
                        bank_addr[k] = pix_idx[k];
                     end
                  end
                  ACT_QUERY: begin
                     ch_in    = req_query_channel;
                     bin_in   = req_range_start;
                     start_in = req_range_start;
                     end_in   = req_range_end;
                     n_in     = '0;
                     s1_in    = '0;
                     s2_in    = '0;
                     cum_in   = '0;
                     peak_in  = '0;
                     med_in   = '0;
                     mean_in  = '0;
                     sd_in    = '0;
                     err_in   = (req_query_channel > CH_ALPHA)
                             || (req_range_start > req_range_end)
                             || (32'(req_range_end) > 32'(BINS - 1));
                     state_in = err_in ? S_DONE : S_SCAN_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // First pass: count, first and second moments, peak
         S_SCAN_RD: begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
               if (3'(k) == ch_ff) begin
                  bank_op[k]   = BANK_READ;
                  bank_addr[k] = IDX_W'(bin_ff);
               end
            end
            state_in = S_SCAN_ACC;
         end

         S_SCAN_ACC: begin
            n_in = n_ff + SUM_W'(c);
            if (c > peak_ff) begin
               peak_in = c;
            end
            p_in     = SUM_W'(p_w);
            state_in = S_SCAN_S1;
         end

         S_SCAN_S1: begin
            s1_in    = s1_ff + p_ff;
            q_in     = q_w[SUM_W-1:0];
            state_in = S_SCAN_S2;
         end

         S_SCAN_S2: begin
            s2_in = s2_ff + q_ff;
            if (bin_ff == end_ff) begin
               bin_in   = start_ff;
               cum_in   = '0;
               state_in = S_MED_RD;
            end else begin
               bin_in   = bin_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end

         // Second pass: median search
         S_MED_RD: begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
               if (3'(k) == ch_ff) begin
                  bank_op[k]   = BANK_READ;
                  bank_addr[k] = IDX_W'(bin_ff);
               end
            end
            state_in = S_MED_CHK;
         end

         S_MED_CHK: begin
            cum_in = cum_w;
            if ((cum_w << 1) > n_ff) begin
               med_in   = bin_ff;
               state_in = (n_ff == '0) ? S_DONE : S_DIV_GO;
            end else if (bin_ff == end_ff) begin
               state_in = (n_ff == '0) ? S_DONE : S_DIV_GO;
            end else begin
               bin_in   = bin_ff + 1'b1;
               state_in = S_MED_RD;
            end
         end

         // Mean
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end

         S_DIV_WAIT: begin
            if (div_done) begin
               mean_in  = (div_quo > MEAN_MAX) ? MEAN_MAX[MEAN_W-1:0] : div_quo[MEAN_W-1:0];
               state_in = S_MULA_GO;
            end
         end

         // Variance numerator n*S2 - S1^2
         S_MULA_GO: begin
            mul_start = 1'b1;
            state_in  = S_MULA_WAIT;
         end

         S_MULA_WAIT: begin
            if (mul_done) begin
               aprod_in = mul_prod;
               state_in = S_MULB_GO;
            end
         end

         S_MULB_GO: begin
            mul_start = 1'b1;
            state_in  = S_MULB_WAIT;
         end

         S_MULB_WAIT: begin
            if (mul_done) begin
               t_in      = var_w;
               sd_bit_in = 4'(SD_BITS - 1);
               state_in  = S_SD_GO;
            end
         end

         // Square root, one result bit per multiplier pass
         S_SD_GO: begin
            mul_start = 1'b1;
            state_in  = S_SD_WAIT;
         end

         S_SD_WAIT: begin
            if (mul_done) begin
               if (mul_prod <= t_ff) begin
                  sd_in = cand;
               end
               if (sd_bit_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  sd_bit_in = sd_bit_ff - 1'b1;
                  state_in  = S_SD_GO;
               end
            end
         end

         // Load the result register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               total_in     = (n_ff > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : n_ff[TOTAL_W-1:0];
               omean_in     = mean_ff;
               omed_in      = med_ff;
               osd_in       = sd_ff;
               opeak_in     = (peak_x > PEAK_MAX) ? PEAK_MAX[PEAK_W-1:0] : peak_x[PEAK_W-1:0];
               oerr_in      = err_ff;
               state_in     = S_RUN;
            end
         end

         default: begin
            state_in = S_SWEEP;
            sweep_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ch_ff     <= ch_in;
      bin_ff    <= bin_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
      err_ff    <= err_in;
      n_ff      <= n_in;
      s1_ff     <= s1_in;
      s2_ff     <= s2_in;
      p_ff      <= p_in;
      q_ff      <= q_in;
      cum_ff    <= cum_in;
      peak_ff   <= peak_in;
      med_ff    <= med_in;
      mean_ff   <= mean_in;
      sd_ff     <= sd_in;
      sd_bit_ff <= sd_bit_in;
      aprod_ff  <= aprod_in;
      t_ff      <= t_in;
      total_ff  <= total_in;
      omean_ff  <= omean_in;
      omed_ff   <= omed_in;
      osd_ff    <= osd_in;
      opeak_ff  <= opeak_in;
      oerr_ff   <= oerr_in;
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bin_total   = total_ff;
   assign rsp_mean_q8     = omean_ff;
   assign rsp_median_bin  = omed_ff;
   assign rsp_stddev_q8   = osd_ff;
   assign rsp_peak_count  = opeak_ff;
   assign rsp_range_error = oerr_ff;

endmodule

### tb/rhs_stats_checker.sv
// Checker for the RGBA histogram block: tracks the histograms, predicts query statistics, compares.
`timescale 1ns / 100ps
module rhs_stats_checker import rhs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [SAMPLE_W-1:0] req_blue_sample,
   input  logic [SAMPLE_W-1:0] req_green_sample,
   input  logic [SAMPLE_W-1:0] req_red_sample,
   input  logic [SAMPLE_W-1:0] req_alpha_sample,
   input  logic [2:0]          req_query_channel,
   input  logic [SAMPLE_W-1:0] req_range_start,
   input  logic [SAMPLE_W-1:0] req_range_end,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [TOTAL_W-1:0]  rsp_bin_total,
   input  logic [MEAN_W-1:0]   rsp_mean_q8,
   input  logic [SAMPLE_W-1:0] rsp_median_bin,
   input  logic [SD_BITS-1:0]  rsp_stddev_q8,
   input  logic [PEAK_W-1:0]   rsp_peak_count,
   input  logic                rsp_range_error,
   output int                  fail_count,
   output int                  pending_stats
);

   typedef struct packed {
      logic [TOTAL_W-1:0]  total;
      logic [MEAN_W-1:0]   mean;
      logic [SAMPLE_W-1:0] median;
      logic [SD_BITS-1:0]  sd;
      logic [PEAK_W-1:0]   peak;
      logic                err;
   } range_stats_type;

   // Per-channel bin counters, indexed by channel code
   logic [31:0]     hist [NUM_CHANNELS][256];
   range_stats_type stats_queue [$];
   int              mismatches;

   assign fail_count    = mismatches;
   assign pending_stats = stats_queue.size();

   initial mismatches = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   function automatic void clear_hist();
      for (int c = 0; c < NUM_CHANNELS; c++)
         for (int i = 0; i < 256; i++)
            hist[c][i] = '0;
   endfunction

   // Saturating bin increment
   function automatic void bump_bin(input int c, input logic [7:0] idx);
      if (hist[c][idx] != '1)
         hist[c][idx] = hist[c][idx] + 1;
   endfunction

   function automatic range_stats_type range_statistics(input logic [2:0] ch,
                                                        input logic [7:0] first,
                                                        input logic [7:0] last);
      range_stats_type res;
      bit [63:0]  n, s1, s2, peak, cum, mean, q, c;
      bit [127:0] spread, q2;
      bit [14:0]  sd, cand;
      bit         found;
      res = '0;
      n = 0; s1 = 0; s2 = 0; peak = 0; cum = 0; mean = 0; sd = 0; found = 0;
      if (ch > CH_ALPHA || first > last) begin
         res.err = 1'b1;
         return res;
      end
      for (int i = first; i <= last; i++) begin
         c = hist[ch][i];
         n += c;
         s1 += 64'(i) * c;
         s2 += 64'(i * i) * c;
         if (c > peak) peak = c;
      end
      // Median: first bin where cumulative count passes half the total
      for (int i = first; i <= last && !found; i++) begin
         cum += hist[ch][i];
         if (2 * cum > n) begin
            res.median = 8'(i);
            found = 1;
         end
      end
      if (n != 0) begin
         mean = (s1 << FRAC_BITS) / n;
         if (mean > MEAN_MAX) mean = MEAN_MAX;
         spread = (128'(n) * 128'(s2) - 128'(s1) * 128'(s1)) << VAR_SHIFT;
         // Integer square root, bit by bit
         for (int b = SD_BITS - 1; b >= 0; b--) begin
            cand = sd | (15'd1 << b);
            q = 64'(cand) * n;
            q2 = 128'(q) * 128'(q);
            if (q2 <= spread) sd = cand;
         end
      end
      res.total = n > TOTAL_MAX ? TOTAL_MAX[TOTAL_W-1:0] : n[TOTAL_W-1:0];
      res.mean  = mean[MEAN_W-1:0];
      res.sd    = sd;
      res.peak  = peak > PEAK_MAX ? PEAK_MAX[PEAK_W-1:0] : peak[PEAK_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      range_stats_type want;
      logic [7:0]      vmax;
      if (reset) begin
         clear_hist();
         stats_queue.delete();
      end else begin
         // Request transaction
         if (req_valid && !req_stall) begin
            case (req_action)
               ACT_CLEAR: clear_hist();
               ACT_PIXEL: begin
                  vmax = req_blue_sample > req_green_sample ? req_blue_sample
                                                            : req_green_sample;
                  if (req_red_sample > vmax) vmax = req_red_sample;
                  bump_bin(CH_BLUE, req_blue_sample);
                  bump_bin(CH_GREEN, req_green_sample);
                  bump_bin(CH_RED, req_red_sample);
                  bump_bin(CH_ALPHA, req_alpha_sample);
                  bump_bin(CH_VALUE, vmax);
               end
               ACT_QUERY: stats_queue.push_back(range_statistics(req_query_channel,
                                                   req_range_start, req_range_end));
               default: ;
            endcase
         end
         // Result transaction
         if (rsp_valid && !rsp_stall) begin
            if (stats_queue.size() == 0) begin
               report_mismatch("unexpected result, total", rsp_bin_total, 0);
            end else begin
               want = stats_queue.pop_front();
               if (rsp_bin_total !== want.total)
                  report_mismatch("bin_total", rsp_bin_total, want.total);
               if (rsp_mean_q8 !== want.mean)
                  report_mismatch("mean_q8", rsp_mean_q8, want.mean);
               if (rsp_median_bin !== want.median)
                  report_mismatch("median_bin", rsp_median_bin, want.median);
               if (rsp_stddev_q8 !== want.sd)
                  report_mismatch("stddev_q8", rsp_stddev_q8, want.sd);
               if (rsp_peak_count !== want.peak)
                  report_mismatch("peak_count", rsp_peak_count, want.peak);
               if (rsp_range_error !== want.err)
                  report_mismatch("range_error", rsp_range_error, want.err);
            end
         end
      end
   end

endmodule

### tb/rgba_histogram_statistics_test.sv
// Top of the RGBA histogram test: clock, reset, stimulus with idle phases, and the verdict.
`timescale 1ns / 100ps
module rgba_histogram_statistics_test;
   import rhs_pkg::*;

   logic                clock, reset;
   logic                req_valid, req_stall;
   logic [1:0]          req_action;
   logic [SAMPLE_W-1:0] req_blue_sample, req_green_sample, req_red_sample, req_alpha_sample;
   logic [2:0]          req_query_channel;
   logic [SAMPLE_W-1:0] req_range_start, req_range_end;
   logic                rsp_valid, rsp_stall;
   logic [TOTAL_W-1:0]  rsp_bin_total;
   logic [MEAN_W-1:0]   rsp_mean_q8;
   logic [SAMPLE_W-1:0] rsp_median_bin;
   logic [SD_BITS-1:0]  rsp_stddev_q8;
   logic [PEAK_W-1:0]   rsp_peak_count;
   logic                rsp_range_error;
   int                  fail_count, pending_stats;
   int                  idle_pct, stall_pct;

   localparam int RANDOM_ITEMS = 1080;

   // Codes outside the legal set
   localparam logic [1:0] ACT_RESERVED = 2'd3;
   localparam logic [2:0] CH_BAD_LO    = 3'd5;
   localparam logic [2:0] CH_BAD_HI    = 3'd7;

   rgba_histogram_statistics dut (.*);
   rhs_stats_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Run limit
   initial begin
      #100_000_000;
      $display("FAIL");
      $finish;
   end

   // Result side stalls
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   // Drive one transaction and hold it until accepted
   task automatic send(input logic [1:0] act, input logic [7:0] b, input logic [7:0] g,
                       input logic [7:0] r, input logic [7:0] a, input logic [2:0] ch,
                       input logic [7:0] first, input logic [7:0] last);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         req_valid = 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_action = act; req_blue_sample = b; req_green_sample = g;
      req_red_sample = r; req_alpha_sample = a; req_query_channel = ch;
      req_range_start = first; req_range_end = last;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                        input logic [7:0] a);
      send(ACT_PIXEL, b, g, r, a, 3'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic query(input logic [2:0] ch, input logic [7:0] first,
                        input logic [7:0] last);
      send(ACT_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
           ch, first, last);
   endtask

   initial begin
      logic [7:0] x, y, base;
      int         pick;
      idle_pct = 0; stall_pct = 0;
      reset = 1; req_valid = 0; req_action = ACT_CLEAR;
      req_blue_sample = 0; req_green_sample = 0; req_red_sample = 0; req_alpha_sample = 0;
      req_query_channel = CH_VALUE; req_range_start = 0; req_range_end = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: empty histograms, extremes, each channel, bad queries
      query(CH_VALUE, 8'd0, 8'd255);
      pixel(8'd0, 8'd0, 8'd0, 8'd0);
      pixel(8'd255, 8'd255, 8'd255, 8'd255);
      pixel(8'd200, 8'd10, 8'd20, 8'd77);
      pixel(8'd10, 8'd200, 8'd20, 8'd1);
      pixel(8'd10, 8'd20, 8'd200, 8'd128);
      send(ACT_RESERVED, 8'd99, 8'd99, 8'd99, 8'd99, CH_RED, 8'd0, 8'd255);
      query(CH_VALUE, 8'd0, 8'd255);
      query(CH_RED, 8'd0, 8'd255);
      query(CH_GREEN, 8'd0, 8'd255);
      query(CH_BLUE, 8'd0, 8'd255);
      query(CH_ALPHA, 8'd0, 8'd255);
      query(CH_RED, 8'd255, 8'd255);
      query(CH_GREEN, 8'd30, 8'd150);
      query(CH_BAD_LO, 8'd0, 8'd255);
      query(CH_BAD_HI, 8'd0, 8'd0);
      query(CH_BLUE, 8'd9, 8'd8);
      send(ACT_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, CH_VALUE, 8'd0, 8'd0);
      query(CH_ALPHA, 8'd0, 8'd255);

      // Random part in four idling phases
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         case (k * 4 / RANDOM_ITEMS)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 75; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 25; stall_pct = 25; end
         endcase
         pick = $urandom_range(99);
         if (pick < 80) begin
            // Pixels, often clustered so ranges hold shaped distributions
            if ($urandom_range(1)) begin
               base = 8'($urandom);
               pixel(8'(base + $urandom_range(15)), 8'(base + $urandom_range(15)),
                     8'(base + $urandom_range(15)), 8'(base + $urandom_range(15)));
            end else begin
               pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
         end else if (pick < 94) begin
            x = 8'($urandom); y = 8'($urandom);
            if ($urandom_range(9) == 0)
               query(3'($urandom_range(7)), x, y);
            else if (x <= y)
               query(3'($urandom_range(4)), x, y);
            else
               query(3'($urandom_range(4)), y, x);
         end else if (pick < 96) begin
            send(ACT_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 3'($urandom), 8'($urandom), 8'($urandom));
         end else if (pick < 98) begin
            send(ACT_RESERVED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 3'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            query(3'($urandom_range(4)), 8'd0, 8'd255);
         end
      end
      @(negedge clock);
      req_valid = 0;

      while (pending_stats != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### filelist.f
rtl/rhs_pkg.sv
rtl/rhs_bank.sv
rtl/rhs_mul.sv
rtl/rhs_div.sv
rtl/rgba_histogram_statistics.sv
tb/rhs_stats_checker.sv
tb/rgba_histogram_statistics_test.sv
